[rtl/pidaw_pkg.sv]
// Shared types, widths, register indexes and saturation helpers for the PID controller.
package pidaw_pkg;

	localparam int SAMPLE_WIDTH = 16;

	localparam int GAIN_W    = 24;
	localparam int DT_W      = 16;
	localparam int Q_W       = 48;
	localparam int LIM_W     = 32;
	localparam int OUT_ERR_W = 17;

	localparam int ERR_W  = SAMPLE_WIDTH + 1;
	localparam int DE_W   = ERR_W + 1;
	localparam int EMAG_W = SAMPLE_WIDTH;
	localparam int DMAG_W = SAMPLE_WIDTH + 1;

	localparam int MX_W = (DMAG_W > DT_W) ? DMAG_W : DT_W;
	localparam int PR_W = MX_W + GAIN_W;
	localparam int A_W  = GAIN_W + EMAG_W;
	localparam int B_W  = GAIN_W + DMAG_W;

	localparam int RND_SHIFT = 10;
	localparam int RND_HALF  = 1 << (RND_SHIFT - 1);

	localparam int PD_W      = A_W + DT_W + 1;
	localparam int DV_W      = B_W + RND_SHIFT;
	localparam int DIV_CNT_W = $clog2(DV_W + 1);
	localparam int WIDE_W    = PD_W;
	localparam int SUM_W     = Q_W + 2;

	localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + DT_W + 7) / 8) * 8;
	localparam int OUT_USED_W = OUT_ERR_W + 4 * Q_W + LIM_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;
	localparam int OUT_USER_W = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDUP_GUARD = 3'd5;

	localparam logic signed [LIM_W-1:0] OUT_MAX_RST = 32'sd6553600;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef struct packed {
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [GAIN_W-1:0]        deriv_gain;
		logic signed [LIM_W-1:0]  out_min;
		logic signed [LIM_W-1:0]  out_max;
		logic                     windup_guard;
	} cfg_t;

	typedef struct packed {
		logic signed [OUT_ERR_W-1:0] err_value;
		logic signed [Q_W-1:0]       p_term;
		logic signed [Q_W-1:0]       i_term;
		logic signed [Q_W-1:0]       d_term;
		logic signed [Q_W-1:0]       raw_drive;
		logic signed [LIM_W-1:0]     drive;
		logic                        clamped;
		logic                        invalid;
	} res_t;

	// Apply a sign to a magnitude, saturating to the Q32.16 range.
	function automatic logic signed [Q_W-1:0] sign_sat(input logic [WIDE_W-1:0] mag,
			input logic neg);
		logic [WIDE_W-1:0] lim;
		logic [Q_W-1:0]    m_lo;
		lim  = WIDE_W'(1) << (Q_W - 1);
		m_lo = mag[Q_W-1:0];
		if (neg) begin
			return (mag >= lim) ? Q_MIN : $signed(Q_W'(0) - m_lo);
		end
		return (mag >= lim) ? Q_MAX : $signed(m_lo);
	endfunction

	// Saturate a widened sum to the Q32.16 range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
		if (x > $signed({{(SUM_W-Q_W){1'b0}}, Q_MAX})) begin
			return Q_MAX;
		end
		if (x < $signed({{(SUM_W-Q_W){1'b1}}, Q_MIN})) begin
			return Q_MIN;
		end
		return x[Q_W-1:0];
	endfunction

endpackage

[rtl/pidaw_cfg.sv]
// Configuration register file: gains, output limits and anti-windup enable.
module pidaw_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pidaw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pidaw_pkg::cfg_t                    cfg
);
	import pidaw_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= '0;
			cfg_q.integ_gain   <= '0;
			cfg_q.deriv_gain   <= '0;
			cfg_q.out_min      <= '0;
			cfg_q.out_max      <= OUT_MAX_RST;
			cfg_q.windup_guard <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data[GAIN_W-1:0];
				REG_OUT_MIN:      cfg_q.out_min      <= $signed(cfg_data[LIM_W-1:0]);
				REG_OUT_MAX:      cfg_q.out_max      <= $signed(cfg_data[LIM_W-1:0]);
				REG_WINDUP_GUARD: cfg_q.windup_guard <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/pidaw_div.sv]
// Restoring divider, one quotient bit per cycle, for the derivative term.
module pidaw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pidaw_pkg::DV_W-1:0]    dividend,
	input  logic [pidaw_pkg::DT_W-1:0]    divisor,
	output logic                          done,
	output logic [pidaw_pkg::DV_W-1:0]    quotient
);
	import pidaw_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DV_W-1:0]      num_q;
	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      dsr_q;
	logic [DT_W:0]        trial;
	logic [DT_W:0]        diff;
	logic                 ge;

	assign trial    = {rem_q, num_q[DV_W-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign diff     = trial - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DV_W);
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
			num_q <= {num_q[DV_W-2:0], ge};
		end
	end

endmodule

[rtl/pidaw_core.sv]
// Sequencer and shared multiplier datapath that evaluates one PID sample.
module pidaw_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] target,
	input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] sensed,
	input  logic [pidaw_pkg::DT_W-1:0]               step_time,
	input  pidaw_pkg::cfg_t                          cfg,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output pidaw_pkg::res_t                          res
);
	import pidaw_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ABS    = 4'd1;
	localparam logic [3:0] S_MUL_P  = 4'd2;
	localparam logic [3:0] S_MUL_A  = 4'd3;
	localparam logic [3:0] S_MUL_L  = 4'd4;
	localparam logic [3:0] S_MUL_H  = 4'd5;
	localparam logic [3:0] S_FULL   = 4'd6;
	localparam logic [3:0] S_MUL_B  = 4'd7;
	localparam logic [3:0] S_DIV_GO = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_SUM    = 4'd10;
	localparam logic [3:0] S_COUT   = 4'd11;
	localparam logic [3:0] S_KEEP   = 4'd12;
	localparam logic [3:0] S_RAW    = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;

	logic [3:0]               state_q;
	logic                     res_valid_q;
	res_t                     res_q;
	res_t                     res_d;

	logic signed [ERR_W-1:0]  err_q;
	logic [DT_W-1:0]          dt_q;
	logic                     inv_q;
	logic [EMAG_W-1:0]        emag_q;
	logic signed [DE_W-1:0]   de_q;
	logic [DMAG_W-1:0]        demag_q;
	logic                     de_neg_q;
	logic [PR_W-1:0]          prod_q;
	logic [A_W-1:0]           a_q;
	logic [PR_W-1:0]          lo_q;
	logic [PD_W-1:0]          full_q;
	logic signed [Q_W-1:0]    p_q;
	logic signed [Q_W-1:0]    inc_q;
	logic signed [Q_W-1:0]    d_q;
	logic signed [Q_W:0]      t_q;
	logic signed [Q_W-1:0]    cand_i_q;
	logic signed [Q_W-1:0]    cand_out_q;
	logic signed [Q_W-1:0]    raw_q;

	logic signed [Q_W-1:0]    accum_q;
	logic signed [ERR_W-1:0]  last_q;
	logic                     have_last_q;

	logic [MX_W-1:0]          mul_x;
	logic [GAIN_W-1:0]        mul_y;
	logic [PR_W-1:0]          mul_p;

	logic                     div_start;
	logic [DV_W-1:0]          div_dividend;
	logic                     div_done;
	logic [DV_W-1:0]          div_quot;

	logic                     accept;
	logic                     err_neg;
	logic                     err_pos;
	logic                     hold_integ;
	logic                     out_free;
	logic                     raw_hi;
	logic                     raw_lo;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || res_ready;

	assign err_neg = err_q[ERR_W-1];
	assign err_pos = !err_neg && (err_q != '0);

	assign hold_integ = cfg.windup_guard &&
		((cand_out_q > cfg.out_max && err_pos) || (cand_out_q < cfg.out_min && err_neg));

	assign raw_hi = raw_q > cfg.out_max;
	assign raw_lo = raw_q < cfg.out_min;

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			S_MUL_P: begin
				mul_x = MX_W'(emag_q);
				mul_y = cfg.prop_gain;
			end
			S_MUL_A: begin
				mul_x = MX_W'(emag_q);
				mul_y = cfg.integ_gain;
			end
			S_MUL_L: begin
				mul_x = MX_W'(dt_q);
				mul_y = prod_q[GAIN_W-1:0];
			end
			S_MUL_H: begin
				mul_x = MX_W'(a_q[A_W-1:GAIN_W]);
				mul_y = GAIN_W'(dt_q);
			end
			S_MUL_B: begin
				mul_x = MX_W'(demag_q);
				mul_y = cfg.deriv_gain;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_x * mul_y;

	assign div_start    = (state_q == S_DIV_GO);
	assign div_dividend = (DV_W'(prod_q[B_W-1:0]) << RND_SHIFT) + DV_W'(dt_q >> 1);

	pidaw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		res_d = '0;
		if (inv_q) begin
			res_d.invalid = 1'b1;
		end else begin
			res_d.err_value = err_q[OUT_ERR_W-1:0];
			res_d.p_term    = p_q;
			res_d.i_term    = accum_q;
			res_d.d_term    = d_q;
			res_d.raw_drive = raw_q;
			res_d.drive     = raw_hi ? cfg.out_max :
				(raw_lo ? cfg.out_min : raw_q[LIM_W-1:0]);
			res_d.clamped   = raw_hi || raw_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			accum_q     <= '0;
			last_q      <= '0;
			have_last_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && state_q != S_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (step_time == '0 || cfg.out_min >= cfg.out_max) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_ABS;
						end
					end
				end
				S_ABS:    state_q <= S_MUL_P;
				S_MUL_P:  state_q <= S_MUL_A;
				S_MUL_A:  state_q <= S_MUL_L;
				S_MUL_L:  state_q <= S_MUL_H;
				S_MUL_H:  state_q <= S_FULL;
				S_FULL:   state_q <= S_MUL_B;
				S_MUL_B:  state_q <= have_last_q ? S_DIV_GO : S_SUM;
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM:    state_q <= S_COUT;
				S_COUT:   state_q <= S_KEEP;
				S_KEEP: begin
					if (!hold_integ) begin
						accum_q <= cand_i_q;
					end
					last_q      <= err_q;
					have_last_q <= 1'b1;
					state_q     <= S_RAW;
				end
				S_RAW:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					err_q <= {target[SAMPLE_WIDTH-1], target} - {sensed[SAMPLE_WIDTH-1], sensed};
					dt_q  <= step_time;
					inv_q <= (step_time == '0) || (cfg.out_min >= cfg.out_max);
				end
			end
			S_ABS: begin
				emag_q <= err_neg ? EMAG_W'(-err_q) : EMAG_W'(err_q);
				de_q   <= {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};
			end
			S_MUL_P: begin
				prod_q   <= mul_p;
				demag_q  <= de_q[DE_W-1] ? DMAG_W'(-de_q) : DMAG_W'(de_q);
				de_neg_q <= de_q[DE_W-1];
			end
			S_MUL_A: begin
				p_q    <= sign_sat(WIDE_W'(prod_q), err_neg);
				prod_q <= mul_p;
			end
			S_MUL_L: begin
				a_q    <= prod_q[A_W-1:0];
				prod_q <= mul_p;
			end
			S_MUL_H: begin
				lo_q   <= prod_q;
				prod_q <= mul_p;
			end
			S_FULL: begin
				full_q <= (PD_W'(prod_q) << GAIN_W) + PD_W'(lo_q) + PD_W'(RND_HALF);
			end
			S_MUL_B: begin
				inc_q  <= sign_sat(WIDE_W'(full_q >> RND_SHIFT), err_neg);
				prod_q <= mul_p;
				if (!have_last_q) begin
					d_q <= '0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					d_q <= sign_sat(WIDE_W'(div_quot), de_neg_q);
				end
			end
			S_SUM: begin
				t_q      <= {p_q[Q_W-1], p_q} + {d_q[Q_W-1], d_q};
				cand_i_q <= sat_q(SUM_W'(accum_q) + SUM_W'(inc_q));
			end
			S_COUT: begin
				cand_out_q <= sat_q(SUM_W'(t_q) + SUM_W'(cand_i_q));
			end
			S_RAW: begin
				raw_q <= sat_q(SUM_W'(t_q) + SUM_W'(accum_q));
			end
			S_OUT: begin
				if (out_free) begin
					res_q <= res_d;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/pid_controller_anti_windup.sv]
// Top level of the fixed-point PID controller with conditional-integration anti-windup.
//
// Usage:
//   cfg_* writes one register per transfer (index 0 prop_gain, 1 integ_gain,
//   2 deriv_gain, 3 out_min, 4 out_max, 5 windup_guard); cfg_ready is always high.
//   Write configuration only while no sample is in flight.
//   s_axis carries one sample per transfer (target, sensed, step_time).
//   m_axis returns one result per sample: error, P, I and D terms, the raw sum,
//   the clamped drive, and the clamped and invalid flags in tuser.
// Sequencing:
//   A sample with a previous sample on record runs through the bit-serial divider
//   of the derivative term, one quotient bit per cycle over a 51-bit dividend; the
//   first sample after reset skips the divider, and an invalid sample (zero step_time,
//   or out_min not below out_max) goes straight to the output. Five products share
//   one multiplier. s_axis_tready is high only while no sample is worked on, so a new
//   sample is taken only once the previous result is in the output register.
// Reset clears the integrator, the previous error and the first-sample flag,
//   and loads the register reset values (out_max 100.0, anti-windup on).
// A stalled m_axis holds its result; the next sample is still taken and
//   worked on, and waits at the end until the output register is free.
module pid_controller_anti_windup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// target, sensed, step_time
	input  logic [pidaw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// err_value, p_term, i_term, d_term, raw_drive, drive
	output logic [pidaw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// clamped, invalid
	output logic [pidaw_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidaw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pidaw_pkg::*;

	cfg_t                           cfg;
	res_t                           res;
	logic signed [SAMPLE_WIDTH-1:0] target;
	logic signed [SAMPLE_WIDTH-1:0] sensed;
	logic [DT_W-1:0]                step_time;

	assign target    = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign sensed    = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign step_time = s_axis_tdata[2*SAMPLE_WIDTH+DT_W-1:2*SAMPLE_WIDTH];

	pidaw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidaw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.target    (target),
		.sensed    (sensed),
		.step_time (step_time),
		.cfg       (cfg),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.drive, res.raw_drive, res.d_term,
		res.i_term, res.p_term, res.err_value};
	assign m_axis_tuser = {res.invalid, res.clamped};

endmodule

[tb/pid_result_checker.sv]
// Checker for the PID controller: mirrors registers and state, predicts and compares results.
`timescale 1ns / 1ps

module pid_result_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [pidaw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [pidaw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic [pidaw_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidaw_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                   mismatches,
	output int                                   pending,
	output int                                   results_seen,
	output int                                   invalid_seen,
	output int                                   clamped_seen
);
	import pidaw_pkg::*;

	localparam longint Q_HI        = (longint'(1) << (Q_W - 1)) - 1;
	localparam longint Q_LO        = -Q_HI - 1;
	localparam longint INC_MAG_LIM = (longint'(1) << 57) - 1;
	localparam longint DIV_Q_LIM   = longint'(1) << 38;

	localparam int SEN_LSB = SAMPLE_WIDTH;
	localparam int DT_LSB  = 2 * SAMPLE_WIDTH;
	localparam int P_LSB   = OUT_ERR_W;
	localparam int I_LSB   = P_LSB + Q_W;
	localparam int D_LSB   = I_LSB + Q_W;
	localparam int R_LSB   = D_LSB + Q_W;
	localparam int V_LSB   = R_LSB + Q_W;

	longint kp, ki, kd, lim_lo, lim_hi;
	bit     guard_on;
	longint integ_acc, prev_err;
	bit     have_prev;
	res_t   expected_q[$];

	function automatic longint sat_q(input longint x);
		if (x > Q_HI) begin
			return Q_HI;
		end
		if (x < Q_LO) begin
			return Q_LO;
		end
		return x;
	endfunction

	function automatic longint magnitude(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint signed_mag(input longint mag, input bit neg);
		if (neg) begin
			return (mag > Q_HI) ? Q_LO : -mag;
		end
		return (mag > Q_HI) ? Q_HI : mag;
	endfunction

	// One control step: return the result and, for a valid sample, update integrator and previous error.
	function automatic res_t predict_sample(input longint tgt, input longint sen,
			input longint dt);
		res_t   r;
		longint e, p, a, m, inc, d, de, b, qa, cand_i, cand_out, raw, drv;
		r = '0;
		if (dt == 0 || lim_lo >= lim_hi) begin
			r.invalid = 1'b1;
			return r;
		end
		e = tgt - sen;
		p = sat_q(kp * e);
		a = ki * magnitude(e);
		if (a > INC_MAG_LIM / dt) begin
			m = Q_HI + 1;
		end else begin
			m = (a * dt + 512) >>> 10;
		end
		inc = signed_mag(m, e < 0);
		d = 0;
		if (have_prev) begin
			de = e - prev_err;
			b  = kd * magnitude(de);
			qa = b / dt;
			if (qa >= DIV_Q_LIM) begin
				m = Q_HI + 1;
			end else begin
				m = qa * 1024 + (((b % dt) * 1024 + dt / 2) / dt);
			end
			d = signed_mag(m, de < 0);
		end
		cand_i   = sat_q(integ_acc + inc);
		cand_out = sat_q(p + cand_i + d);
		if (!guard_on || !((cand_out > lim_hi && e > 0) || (cand_out < lim_lo && e < 0))) begin
			integ_acc = cand_i;
		end
		raw = sat_q(p + integ_acc + d);
		drv = raw;
		if (drv > lim_hi) begin
			drv = lim_hi;
		end
		if (drv < lim_lo) begin
			drv = lim_lo;
		end
		prev_err  = e;
		have_prev = 1'b1;
		r.err_value = e[OUT_ERR_W-1:0];
		r.p_term    = p[Q_W-1:0];
		r.i_term    = integ_acc[Q_W-1:0];
		r.d_term    = d[Q_W-1:0];
		r.raw_drive = raw[Q_W-1:0];
		r.drive     = drv[LIM_W-1:0];
		r.clamped   = (drv != raw);
		return r;
	endfunction

	task automatic compare_result(input res_t want, input res_t got);
		if (got.err_value !== want.err_value) begin
			$error("err_value: expected %0d, got %0d", want.err_value, got.err_value);
			mismatches++;
		end
		if (got.p_term !== want.p_term) begin
			$error("p_term: expected %0d, got %0d", want.p_term, got.p_term);
			mismatches++;
		end
		if (got.i_term !== want.i_term) begin
			$error("i_term: expected %0d, got %0d", want.i_term, got.i_term);
			mismatches++;
		end
		if (got.d_term !== want.d_term) begin
			$error("d_term: expected %0d, got %0d", want.d_term, got.d_term);
			mismatches++;
		end
		if (got.raw_drive !== want.raw_drive) begin
			$error("raw_drive: expected %0d, got %0d", want.raw_drive, got.raw_drive);
			mismatches++;
		end
		if (got.drive !== want.drive) begin
			$error("drive: expected %0d, got %0d", want.drive, got.drive);
			mismatches++;
		end
		if (got.clamped !== want.clamped) begin
			$error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
			mismatches++;
		end
		if (got.invalid !== want.invalid) begin
			$error("invalid: expected %0d, got %0d", want.invalid, got.invalid);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_t got;
		if (!arst_n) begin
			kp        = 0;
			ki        = 0;
			kd        = 0;
			lim_lo    = 0;
			lim_hi    = longint'(OUT_MAX_RST);
			guard_on  = 1'b1;
			integ_acc = 0;
			prev_err  = 0;
			have_prev = 1'b0;
			expected_q.delete();
			pending   = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.err_value = m_axis_tdata[OUT_ERR_W-1:0];
				got.p_term    = m_axis_tdata[P_LSB +: Q_W];
				got.i_term    = m_axis_tdata[I_LSB +: Q_W];
				got.d_term    = m_axis_tdata[D_LSB +: Q_W];
				got.raw_drive = m_axis_tdata[R_LSB +: Q_W];
				got.drive     = m_axis_tdata[V_LSB +: LIM_W];
				got.clamped   = m_axis_tuser[0];
				got.invalid   = m_axis_tuser[1];
				results_seen++;
				if (got.invalid) begin
					invalid_seen++;
				end
				if (got.clamped) begin
					clamped_seen++;
				end
				if (expected_q.size() == 0) begin
					$error("result transfer with no sample outstanding");
					mismatches++;
				end else begin
					compare_result(expected_q.pop_front(), got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN: begin
						kp = longint'(cfg_data[GAIN_W-1:0]);
					end
					REG_INTEG_GAIN: begin
						ki = longint'(cfg_data[GAIN_W-1:0]);
					end
					REG_DERIV_GAIN: begin
						kd = longint'(cfg_data[GAIN_W-1:0]);
					end
					REG_OUT_MIN: begin
						lim_lo = longint'($signed(cfg_data[LIM_W-1:0]));
					end
					REG_OUT_MAX: begin
						lim_hi = longint'($signed(cfg_data[LIM_W-1:0]));
					end
					REG_WINDUP_GUARD: begin
						guard_on = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_q.push_back(predict_sample(
					longint'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
					longint'($signed(s_axis_tdata[SEN_LSB +: SAMPLE_WIDTH])),
					longint'(s_axis_tdata[DT_LSB +: DT_W])));
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/tb.sv]
// Testbench top for the PID controller: clock, reset, register writes, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import pidaw_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int NUM_PHASES      = 8;
	localparam int PHASE_SAMPLES   = 116;
	localparam int CALM_TX_FIRST   = 300;
	localparam int CALM_TX_LAST    = 500;
	localparam int HOLD_START      = 20000;
	localparam int HOLD_LEN        = 500;
	localparam int CALM_RX_START   = 32000;
	localparam int CALM_RX_END     = 46000;
	localparam int TAIL_CYCLES     = 80;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic [OUT_USER_W-1:0]   m_axis_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	logic s_fire;
	logic cfg_fire;
	bit   sender_calm;
	int   samples_sent;
	int   directed_sent;
	int   reg_writes;
	int   cycle_count;

	int mismatches, pending, results_seen, invalid_seen, clamped_seen;

	pid_controller_anti_windup i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pid_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.results_seen  (results_seen),
		.invalid_seen  (invalid_seen),
		.clamped_seen  (clamped_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_fire   <= 1'b0;
			cfg_fire <= 1'b0;
		end else begin
			s_fire   <= s_axis_tvalid && s_axis_tready;
			cfg_fire <= cfg_valid && cfg_ready;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, one stretch without stalls.
	initial begin
		int rx_cycles;
		m_axis_tready <= 1'b0;
		rx_cycles     = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
				m_axis_tready <= 1'b0;
			end else if (rx_cycles >= CALM_RX_START && rx_cycles < CALM_RX_END) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 7);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has arrived.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] kd, input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] guard);
		drain_results();
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_OUT_MAX, hi);
		write_reg(REG_WINDUP_GUARD, guard);
	endtask

	task automatic send_sample(input int tgt, input int sen, input int dt);
		if (!sender_calm && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({DT_W'(dt), SAMPLE_WIDTH'(sen), SAMPLE_WIDTH'(tgt)});
		do @(negedge clk); while (!s_fire);
		samples_sent++;
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(3))
			0:       return $urandom();
			1:       return $urandom_range(0, 32'h1FFFF);
			2:       return $urandom_range(0, 32'h3FF);
			default: return $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
		endcase
	endfunction

	function automatic int clip_sample(input int v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	initial begin
		int          tgt, sen, dt, span, sel;
		logic [31:0] lo, hi, guard;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		sender_calm   = 1'b0;
		samples_sent  = 0;
		reg_writes    = 0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values: zero step time, then the first valid sample.
		send_sample(0, 0, 0);
		send_sample(100, -100, 1024);

		set_config(32'h010000, 32'h008000, 32'h004000, -32'sd6553600, 32'sd6553600, 1);
		send_sample(32767, -32768, 1);
		send_sample(-32768, 32767, 65535);
		send_sample(7, 2, 0);
		send_sample(0, 0, 1024);
		send_sample(5, 3, 512);

		set_config(32'h010000, 32'h008000, 32'h004000, 32'sd6553600, -32'sd6553600, 1);
		send_sample(10, 0, 100);
		drain_results();
		write_reg(REG_OUT_MAX, 32'sd6553600);
		send_sample(10, 0, 100);

		// Full gains and widest limits, integrator free to saturate.
		set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		send_sample(-32768, 32767, 1);
		send_sample(32767, -32768, 1);
		repeat (3) send_sample(32767, -32768, 65535);

		set_config(32'h000100, 32'h0FFFFF, 32'h0, -32'sd6553600, 32'sd6553600, 1);
		repeat (3) send_sample(1000, 0, 1024);
		repeat (2) send_sample(-1000, 0, 1024);

		drain_results();
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		directed_sent = samples_sent;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			sel = $urandom_range(2);
			if (ph == 0 || sel == 2) begin
				lo = 32'h80000000;
				hi = 32'h7FFFFFFF;
			end else if (sel == 1) begin
				lo = $urandom();
				hi = $urandom();
			end else begin
				span = $urandom_range(1, 32'h7FFFFFFF);
				lo   = -span;
				hi   = $urandom_range(0, span);
			end
			if (ph == 0) begin
				guard = 32'h1;
			end else if (ph == 1) begin
				guard = 32'hFFFFFFFE;
			end else begin
				guard = $urandom();
			end
			set_config(pick_gain(), pick_gain(), pick_gain(), lo, hi, guard);
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				sender_calm = (samples_sent - directed_sent >= CALM_TX_FIRST &&
					samples_sent - directed_sent < CALM_TX_LAST);
				sel = $urandom_range(99);
				if (sel < 4) begin
					dt = 0;
				end else if (sel < 70) begin
					dt = $urandom_range(1, 2048);
				end else begin
					dt = $urandom_range(1, 65535);
				end
				tgt = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(99) < 60) begin
					sen = clip_sample(tgt + int'($urandom_range(0, 400)) - 200);
				end else begin
					sen = int'($urandom_range(0, 65535)) - 32768;
				end
				send_sample(tgt, sen, dt);
			end
		end
		sender_calm = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("summary: %0d samples (%0d directed), %0d register writes, %0d results checked",
			samples_sent, directed_sent, reg_writes, results_seen);
		$display("summary: %0d invalid and %0d clamped results, %0d mismatches",
			invalid_seen, clamped_seen, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
